// ===== rtl/sd_card_spi_command_engine_macros.svh =====
// assertion macros shared by the checker file
`ifndef SD_CARD_SPI_COMMAND_ENGINE_MACROS_SVH
`define SD_CARD_SPI_COMMAND_ENGINE_MACROS_SVH

// property checked only while out of reset
`define SDCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define SDCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sdspi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_pkg
// types and constants shared by the sd card spi command engine
// ----------------------------------------------------------------------------
package sdspi_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_INIT_RETRY   = 2'd0;
  localparam logic [1:0] CFG_TOKEN_TMO    = 2'd1;
  localparam logic [1:0] CFG_BUSY_TMO     = 2'd2;
  localparam logic [1:0] CFG_RESP_ATTEMPT = 2'd3;

  // request codes
  localparam logic [2:0] OP_XDONE  = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_INIT   = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_WBEGIN = 3'd4;
  localparam logic [2:0] OP_WBYTE  = 3'd5;
  localparam logic [2:0] OP_WFIN   = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_NOINIT = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  miso_byte;
    logic [31:0] sector;
    logic [8:0]  offset;
    logic [9:0]  count;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       exchange;
    logic       select_low;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
    logic [1:0] status;
    logic [3:0] card_kind;
  } out_item_t;

  typedef struct packed {
    logic [11:0] init_retry_limit;
    logic [9:0]  read_token_timeout;
    logic [11:0] write_busy_timeout;
    logic [7:0]  response_attempts;
  } cfg_regs_t;

endpackage

// ===== rtl/sd_card_spi_command_engine.sv =====
`timescale 1ns / 1ps
// each item is held in the input register, then its result in the result register
// throughput: one item per cycle while the result side does not stall, set by the single-pass sequencer logic
// both sides decoupled by the input and result registers; stalls hold them in place
// reset (rst_n low, synchronous): idle, card uninitialised, registers at defaults
// ----------------------------------------------------------------------------
// sd_card_spi_command_engine
// spi-mode sd/mmc host engine stepped one byte exchange or tick per item
// ----------------------------------------------------------------------------
module sd_card_spi_command_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sdspi_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sdspi_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  sdspi_pkg::in_item_t  in_r;
  sdspi_pkg::out_item_t out_r, res;
  sdspi_pkg::cfg_regs_t cfg;
  logic                 in_v_r, out_v_r;
  logic                 adv;

  // one step whenever an item is held and the result register is free or drained
  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign cfg_ready = 1'b1;

  sdspi_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  sdspi_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (in_r),
    .cfg   (cfg),
    .res   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_r <= in_data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= res;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/sdspi_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_cfg
// configuration register file of the command engine
// ----------------------------------------------------------------------------
module sdspi_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [31:0]         wr_data,
  output sdspi_pkg::cfg_regs_t regs
);

  sdspi_pkg::cfg_regs_t regs_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.init_retry_limit   <= 12'd1000;
      regs_r.read_token_timeout <= 10'd100;
      regs_r.write_busy_timeout <= 12'd1000;
      regs_r.response_attempts  <= 8'd10;
    end else if (wr_en) begin
      unique case (wr_index)
        sdspi_pkg::CFG_INIT_RETRY:   regs_r.init_retry_limit   <= wr_data[11:0];
        sdspi_pkg::CFG_TOKEN_TMO:    regs_r.read_token_timeout <= wr_data[9:0];
        sdspi_pkg::CFG_BUSY_TMO:     regs_r.write_busy_timeout <= wr_data[11:0];
        sdspi_pkg::CFG_RESP_ATTEMPT: regs_r.response_attempts  <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

// ===== rtl/sdspi_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_core
// sequencer state and single-pass next-state logic, one item per step
// ----------------------------------------------------------------------------
module sdspi_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  sdspi_pkg::in_item_t  item,
  input  sdspi_pkg::cfg_regs_t cfg,
  output sdspi_pkg::out_item_t res
);

  // phases
  localparam logic [3:0] P_IDLE   = 4'd0;
  localparam logic [3:0] P_DUMMY  = 4'd1;
  localparam logic [3:0] P_CMD    = 4'd2;
  localparam logic [3:0] P_R7     = 4'd3;
  localparam logic [3:0] P_ITICK  = 4'd4;
  localparam logic [3:0] P_TTICK  = 4'd5;
  localparam logic [3:0] P_TOKEN  = 4'd6;
  localparam logic [3:0] P_RDATA  = 4'd7;
  localparam logic [3:0] P_WHDR   = 4'd8;
  localparam logic [3:0] P_WBYTE  = 4'd9;
  localparam logic [3:0] P_WFILL  = 4'd10;
  localparam logic [3:0] P_WRESP  = 4'd11;
  localparam logic [3:0] P_WBUSY  = 4'd12;
  localparam logic [3:0] P_WBTICK = 4'd13;
  localparam logic [3:0] P_REL    = 4'd14;

  // command sequence steps
  localparam logic [3:0] S_CMD0  = 4'd0;
  localparam logic [3:0] S_CMD8  = 4'd1;
  localparam logic [3:0] S_LOOP2 = 4'd2;
  localparam logic [3:0] S_CMD58 = 4'd3;
  localparam logic [3:0] S_PROBE = 4'd4;
  localparam logic [3:0] S_LOOP1 = 4'd5;
  localparam logic [3:0] S_CMD16 = 4'd6;
  localparam logic [3:0] S_CMD17 = 4'd7;
  localparam logic [3:0] S_CMD24 = 4'd8;

  localparam logic [9:0] BLK      = 10'd512;
  localparam logic [9:0] BLK_CRC  = 10'd514;

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  seq_r, seq_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [7:0]  cidx_r, cidx_nxt;
  logic [31:0] carg_r, carg_nxt;
  logic [3:0]  fpos_r, fpos_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic [11:0] retry_r, retry_nxt;
  logic [9:0]  bcnt_r, bcnt_nxt;
  logic [8:0]  roff_r, roff_nxt;
  logic [9:0]  rcnt_r, rcnt_nxt;
  logic [9:0]  wrem_r, wrem_nxt;
  logic [7:0]  rep0_r, rep0_nxt;
  logic [7:0]  rep2_r, rep2_nxt;
  logic        app_r, app_nxt;
  logic        sel_r, sel_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [1:0]  est_r, est_nxt;

  // byte of the command frame at a given position
  function automatic logic [7:0] frame_byte(input logic [3:0] pos, input logic app,
                                            input logic [7:0] cidx, input logic [31:0] carg);
    logic [7:0]  code;
    logic [31:0] arg;
    logic [7:0]  fb;
    code = app ? 8'h77 : {1'b0, cidx[6:0]};
    arg  = app ? 32'd0 : carg;
    case (pos)
      4'd2:    fb = code;
      4'd3:    fb = arg[31:24];
      4'd4:    fb = arg[23:16];
      4'd5:    fb = arg[15:8];
      4'd6:    fb = arg[7:0];
      default: fb = (code == 8'h40) ? 8'h95 : ((code == 8'h48) ? 8'h87 : 8'h01);
    endcase
    return fb;
  endfunction

  // next state and result of one item
  always_comb begin
    logic        st_go;
    logic [7:0]  st_cmd;
    logic [31:0] st_arg;
    logic [3:0]  st_seq;
    logic        bl_go;
    logic        ei_go;
    logic [3:0]  ei_ty;
    logic        rl_go;
    logic [1:0]  rl_st;
    logic [9:0]  bc_inc;
    logic [9:0]  bc_rel;
    logic [31:0] addr;
    logic [7:0]  miso;

    st_go = 1'b0; st_cmd = 8'd0; st_arg = 32'd0; st_seq = S_CMD0;
    bl_go = 1'b0; ei_go = 1'b0; ei_ty = 4'd0; rl_go = 1'b0; rl_st = sdspi_pkg::ST_OK;
    miso   = item.miso_byte;
    bc_inc = bcnt_r + 10'd1;
    bc_rel = bcnt_r - {1'b0, roff_r};
    addr   = flags_r[3] ? item.sector : {item.sector[22:0], 9'd0};

    phase_nxt = phase_r; seq_nxt = seq_r; flags_nxt = flags_r; cidx_nxt = cidx_r;
    carg_nxt = carg_r; fpos_nxt = fpos_r; poll_nxt = poll_r; retry_nxt = retry_r;
    bcnt_nxt = bcnt_r; roff_nxt = roff_r; rcnt_nxt = rcnt_r; wrem_nxt = wrem_r;
    rep0_nxt = rep0_r; rep2_nxt = rep2_r; app_nxt = app_r; sel_nxt = sel_r;
    kind_nxt = kind_r; est_nxt = est_r;
    res = '0;

    if (phase_r == P_IDLE) begin
      // new request
      case (item.op)
        sdspi_pkg::OP_INIT: begin
          kind_nxt = 4'd0; sel_nxt = 1'b0; bcnt_nxt = 10'd10; phase_nxt = P_DUMMY;
          res.exchange = 1'b1; res.mosi_byte = 8'hFF;
        end
        sdspi_pkg::OP_READ: begin
          if (flags_r == 4'd0) begin
            res.done_res = 1'b1; res.status = sdspi_pkg::ST_NOINIT;
          end else begin
            roff_nxt = item.offset; rcnt_nxt = item.count;
            st_go = 1'b1; st_cmd = 8'h51; st_arg = addr; st_seq = S_CMD17;
          end
        end
        sdspi_pkg::OP_WBEGIN: begin
          if (flags_r == 4'd0) begin
            res.done_res = 1'b1; res.status = sdspi_pkg::ST_NOINIT;
          end else begin
            st_go = 1'b1; st_cmd = 8'h58; st_arg = addr; st_seq = S_CMD24;
          end
        end
        sdspi_pkg::OP_WBYTE: begin
          if (wrem_r == 10'd0) begin
            res.done_res = 1'b1;
          end else begin
            wrem_nxt = wrem_r - 10'd1; phase_nxt = P_WBYTE;
            res.exchange = 1'b1; res.mosi_byte = item.data_byte;
          end
        end
        sdspi_pkg::OP_WFIN: begin
          bcnt_nxt = wrem_r + 10'd2; phase_nxt = P_WFILL;
          res.exchange = 1'b1;
        end
        default: ;
      endcase
    end else if (phase_r == P_ITICK || phase_r == P_TTICK || phase_r == P_WBTICK) begin
      // millisecond waits
      if (item.op == sdspi_pkg::OP_TICK) begin
        if (phase_r == P_ITICK) begin
          retry_nxt = retry_r - 12'd1;
          if (retry_nxt == 12'd0) begin
            ei_go = 1'b1;
          end else begin
            st_go = 1'b1; st_cmd = cidx_r; st_arg = carg_r; st_seq = seq_r;
          end
        end else if (phase_r == P_TTICK) begin
          phase_nxt = P_TOKEN; res.exchange = 1'b1; res.mosi_byte = 8'hFF;
        end else begin
          retry_nxt = retry_r - 12'd1; phase_nxt = P_WBUSY;
          res.exchange = 1'b1; res.mosi_byte = 8'hFF;
        end
      end
    end else if (item.op == sdspi_pkg::OP_XDONE) begin
      // completed byte exchange
      case (phase_r)
        P_DUMMY: begin
          bcnt_nxt = bcnt_r - 10'd1;
          if (bcnt_nxt != 10'd0) begin
            res.exchange = 1'b1; res.mosi_byte = 8'hFF;
          end else begin
            st_go = 1'b1; st_cmd = 8'h40; st_arg = 32'd0; st_seq = S_CMD0;
          end
        end
        P_CMD: begin
          if (fpos_r < 4'd8) begin
            fpos_nxt = fpos_r + 4'd1;
            res.exchange = 1'b1; res.mosi_byte = 8'hFF;
            if (fpos_nxt == 4'd1) begin
              sel_nxt = 1'b1;
            end else if (fpos_nxt < 4'd8) begin
              res.mosi_byte = frame_byte(fpos_nxt, app_r, cidx_r, carg_r);
            end else begin
              poll_nxt = cfg.response_attempts;
            end
          end else if (miso[7] && (poll_r - 8'd1) != 8'd0) begin
            poll_nxt = poll_r - 8'd1;
            res.exchange = 1'b1; res.mosi_byte = 8'hFF;
          end else if (app_r && miso <= 8'd1) begin
            // prefix accepted, send the command itself
            poll_nxt = miso[7] ? poll_r - 8'd1 : poll_r;
            app_nxt = 1'b0; fpos_nxt = 4'd0; sel_nxt = 1'b0;
            res.exchange = 1'b1; res.mosi_byte = 8'hFF;
          end else begin
            poll_nxt = miso[7] ? poll_r - 8'd1 : poll_r;
            app_nxt = 1'b0;
            // reply dispatch
            case (seq_r)
              S_CMD0: begin
                if (miso == 8'd1) begin
                  st_go = 1'b1; st_cmd = 8'h48; st_arg = 32'h1AA; st_seq = S_CMD8;
                end else begin
                  ei_go = 1'b1;
                end
              end
              S_CMD8, S_CMD58: begin
                if ((seq_r == S_CMD8 && miso == 8'd1) || (seq_r == S_CMD58 && miso == 8'd0))
                begin
                  bcnt_nxt = 10'd0; phase_nxt = P_R7;
                  res.exchange = 1'b1; res.mosi_byte = 8'hFF;
                end else if (seq_r == S_CMD8) begin
                  st_go = 1'b1; st_cmd = 8'hE9; st_arg = 32'd0; st_seq = S_PROBE;
                end else begin
                  ei_go = 1'b1;
                end
              end
              S_LOOP2, S_LOOP1: begin
                if (miso == 8'd0) begin
                  st_go = 1'b1;
                  if (seq_r == S_LOOP2) begin
                    st_cmd = 8'h7A; st_arg = 32'd0; st_seq = S_CMD58;
                  end else begin
                    st_cmd = 8'h50; st_arg = 32'd512; st_seq = S_CMD16;
                  end
                end else begin
                  phase_nxt = P_ITICK;
                end
              end
              S_PROBE: begin
                bl_go = 1'b1; st_arg = 32'd0; st_seq = S_LOOP1;
                if (miso <= 8'd1) begin
                  kind_nxt = 4'd2; st_cmd = 8'hE9;
                end else begin
                  kind_nxt = 4'd1; st_cmd = 8'h41;
                end
              end
              S_CMD16: begin
                ei_go = 1'b1; ei_ty = (miso == 8'd0) ? kind_r : 4'd0;
              end
              S_CMD17: begin
                if (miso == 8'd0) begin
                  retry_nxt = {2'd0, cfg.read_token_timeout}; phase_nxt = P_TTICK;
                end else begin
                  rl_go = 1'b1; rl_st = sdspi_pkg::ST_ERR;
                end
              end
              default: begin
                if (miso == 8'd0) begin
                  bcnt_nxt = 10'd0; phase_nxt = P_WHDR;
                  res.exchange = 1'b1; res.mosi_byte = 8'hFF;
                end else begin
                  phase_nxt = P_IDLE; res.done_res = 1'b1; res.status = sdspi_pkg::ST_ERR;
                end
              end
            endcase
          end
        end
        P_R7: begin
          if (bcnt_r[1:0] == 2'd0) rep0_nxt = miso;
          if (bcnt_r[1:0] == 2'd2) rep2_nxt = miso;
          bcnt_nxt = bc_inc;
          if (bc_inc < 10'd4) begin
            res.exchange = 1'b1; res.mosi_byte = 8'hFF;
          end else if (seq_r == S_CMD8) begin
            if (rep2_r == 8'h01 && miso == 8'hAA) begin
              bl_go = 1'b1; st_cmd = 8'hE9; st_arg = 32'h4000_0000; st_seq = S_LOOP2;
            end else begin
              ei_go = 1'b1;
            end
          end else begin
            ei_go = 1'b1; ei_ty = rep0_r[6] ? 4'd12 : 4'd4;
          end
        end
        P_TOKEN: begin
          if (miso == 8'hFF) begin
            retry_nxt = {2'd0, retry_r[9:0] - 10'd1};
            if (retry_nxt != 12'd0) begin
              phase_nxt = P_TTICK;
            end else begin
              rl_go = 1'b1; rl_st = sdspi_pkg::ST_ERR;
            end
          end else if (miso == 8'hFE) begin
            bcnt_nxt = 10'd0; phase_nxt = P_RDATA;
            res.exchange = 1'b1; res.mosi_byte = 8'hFF;
          end else begin
            rl_go = 1'b1; rl_st = sdspi_pkg::ST_ERR;
          end
        end
        P_RDATA: begin
          if (bcnt_r >= {1'b0, roff_r} && bc_rel < rcnt_r && bcnt_r < BLK) begin
            res.read_valid = 1'b1; res.read_byte = miso;
          end
          bcnt_nxt = bc_inc;
          if (bc_inc < BLK_CRC) begin
            res.exchange = 1'b1; res.mosi_byte = 8'hFF;
          end else begin
            rl_go = 1'b1;
          end
        end
        P_WHDR: begin
          if (bcnt_r == 10'd0) begin
            bcnt_nxt = 10'd1; res.exchange = 1'b1; res.mosi_byte = 8'hFE;
          end else begin
            wrem_nxt = BLK; phase_nxt = P_IDLE; res.done_res = 1'b1;
          end
        end
        P_WBYTE: begin
          phase_nxt = P_IDLE; res.done_res = 1'b1;
        end
        P_WFILL: begin
          bcnt_nxt = bcnt_r - 10'd1; res.exchange = 1'b1;
          if (bcnt_nxt == 10'd0) begin
            phase_nxt = P_WRESP; res.mosi_byte = 8'hFF;
          end
        end
        P_WRESP: begin
          if (miso[4:0] == 5'h05) begin
            retry_nxt = cfg.write_busy_timeout; phase_nxt = P_WBUSY;
            res.exchange = 1'b1; res.mosi_byte = 8'hFF;
          end else begin
            rl_go = 1'b1; rl_st = sdspi_pkg::ST_ERR;
          end
        end
        P_WBUSY: begin
          if (miso == 8'hFF) begin
            rl_go = 1'b1; rl_st = (retry_r != 12'd0) ? sdspi_pkg::ST_OK : sdspi_pkg::ST_ERR;
          end else if (retry_r == 12'd0) begin
            rl_go = 1'b1; rl_st = sdspi_pkg::ST_ERR;
          end else begin
            phase_nxt = P_WBTICK;
          end
        end
        default: begin
          phase_nxt = P_IDLE; res.done_res = 1'b1; res.status = est_r;
        end
      endcase
    end

    // retry loop entry
    if (bl_go) begin
      retry_nxt = cfg.init_retry_limit;
      if (cfg.init_retry_limit == 12'd0) ei_go = 1'b1;
      else st_go = 1'b1;
    end
    // end of identification
    if (ei_go) begin
      flags_nxt = ei_ty; rl_go = 1'b1;
      rl_st = (ei_ty != 4'd0) ? sdspi_pkg::ST_OK : sdspi_pkg::ST_NOINIT;
    end
    // deselect and one trailing byte
    if (rl_go) begin
      est_nxt = rl_st; sel_nxt = 1'b0; phase_nxt = P_REL;
      res.exchange = 1'b1; res.mosi_byte = 8'hFF;
    end
    // command frame start
    if (st_go) begin
      cidx_nxt = st_cmd; carg_nxt = st_arg; seq_nxt = st_seq; app_nxt = st_cmd[7];
      fpos_nxt = 4'd0; sel_nxt = 1'b0; phase_nxt = P_CMD;
      res.exchange = 1'b1; res.mosi_byte = 8'hFF;
    end

    res.select_low = sel_nxt;
    res.card_kind  = flags_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE; seq_r <= S_CMD0; flags_r <= '0; cidx_r <= '0; carg_r <= '0;
      fpos_r <= '0; poll_r <= '0; retry_r <= '0; bcnt_r <= '0; roff_r <= '0;
      rcnt_r <= '0; wrem_r <= '0; rep0_r <= '0; rep2_r <= '0; app_r <= 1'b0;
      sel_r <= 1'b0; kind_r <= '0; est_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; seq_r <= seq_nxt; flags_r <= flags_nxt; cidx_r <= cidx_nxt;
      carg_r <= carg_nxt; fpos_r <= fpos_nxt; poll_r <= poll_nxt; retry_r <= retry_nxt;
      bcnt_r <= bcnt_nxt; roff_r <= roff_nxt; rcnt_r <= rcnt_nxt; wrem_r <= wrem_nxt;
      rep0_r <= rep0_nxt; rep2_r <= rep2_nxt; app_r <= app_nxt; sel_r <= sel_nxt;
      kind_r <= kind_nxt; est_r <= est_nxt;
    end
  end

endmodule

// ===== rtl/sdspi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_checker
// port-level checks of the command engine, bound to the top level
// ----------------------------------------------------------------------------
`include "sd_card_spi_command_engine_macros.svh"

module sdspi_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input sdspi_pkg::out_item_t out_data
);

  // stalled result holds
  `SDCE_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result dropped")
  // nothing offered right after reset
  `SDCE_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_valid, "result after reset")
  // no byte without an exchange
  `SDCE_ASSERT(a_mosi, out_valid && !out_data.exchange |-> out_data.mosi_byte == 8'd0, "stray mosi")
  // block data never ends a request
  `SDCE_ASSERT(a_rd, out_valid && out_data.read_valid |-> !out_data.done_res, "read and done")

endmodule

bind sd_card_spi_command_engine sdspi_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
